>>> design/rpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangular/polar converter package
// Shared types, the CORDIC arctangent table and fixed-point constants.
// ----------------------------------------------------------------------------
package rpc_pkg;

  typedef enum logic {
    CMD_TO_POLAR = 1'b0,
    CMD_TO_RECT  = 1'b1
  } cmd_t;

  // Per-item control that travels with the coordinates through the queue.
  typedef struct packed {
    cmd_t mode;
    logic origin;
    logic negate;
  } rpc_ctl_t;

  localparam int GUARD_BITS  = 16;
  localparam int GAIN_SHIFT  = 30 - GUARD_BITS;
  localparam int PHASE_BITS  = 32;
  localparam int QUEUE_DEPTH = 4;

  // Reciprocal of the CORDIC gain in Q30.
  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032875;

  // Angle accumulator is one bit wider than a turn so the rotation residue keeps its sign.
  localparam logic signed [PHASE_BITS:0] HALF_TURN    = 33'sh0_8000_0000;
  localparam logic signed [PHASE_BITS:0] QUARTER_TURN = 33'sh0_4000_0000;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN32 [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

>>> design/rpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter channel interfaces
// Valid/ready channels for input points and converted results.
// ----------------------------------------------------------------------------
interface rpc_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [DATA_WIDTH-1:0] first_value;
  logic signed [DATA_WIDTH-1:0] second_value;

  modport source (output valid, command, first_value, second_value, input ready);
  modport sink   (input valid, command, first_value, second_value, output ready);
endinterface

interface rpc_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [DATA_WIDTH:0] first_result;
  logic signed [DATA_WIDTH:0] second_result;

  modport source (output valid, first_result, second_result, input ready);
  modport sink   (input valid, first_result, second_result, output ready);
endinterface

>>> design/rpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter front end
// Accepts points, classifies them, removes the CORDIC gain and works out the
// half-turn fold of the angle, flagging the start vector for negation.
// ----------------------------------------------------------------------------
module rpc_front #(
  parameter int DATA_WIDTH = 16,
  parameter int WORK_WIDTH = 34
) (
  input  logic                         clk,
  input  logic                         rst,
  rpc_in_if.sink                       point,
  output logic                         work_valid,
  input  logic                         work_ready,
  output rpc_pkg::rpc_ctl_t            work_ctl,
  output logic signed [WORK_WIDTH-1:0] work_x,
  output logic signed [WORK_WIDTH-1:0] work_y,
  output logic [rpc_pkg::PHASE_BITS:0] work_z
);
  import rpc_pkg::*;

  localparam int PROD_W    = WORK_WIDTH + GAIN_SHIFT;
  localparam int ANG_SHIFT = PHASE_BITS - DATA_WIDTH;

  logic signed [PROD_W-1:0]     prod_a;
  logic signed [PROD_W-1:0]     prod_b;
  logic signed [PHASE_BITS-1:0] phase_in;
  logic signed [PHASE_BITS:0]   resid;
  logic                         fold;
  rpc_ctl_t                     ctl_next;
  logic signed [WORK_WIDTH-1:0] y_next;
  logic [PHASE_BITS:0]          z_next;

  assign point.ready = !work_valid || work_ready;

  assign prod_a = PROD_W'(point.first_value) * PROD_W'(GAIN_Q30);
  assign prod_b = PROD_W'(point.second_value) * PROD_W'(GAIN_Q30);

  assign phase_in = $signed(PHASE_BITS'(point.second_value) << ANG_SHIFT);
  assign resid    = (PHASE_BITS + 1)'(phase_in);
  assign fold     = (resid > QUARTER_TURN) || (resid < -QUARTER_TURN);

  always_comb begin
    ctl_next.mode = cmd_t'(point.command);
    if (ctl_next.mode == CMD_TO_POLAR) begin
      ctl_next.origin = (point.first_value == '0) && (point.second_value == '0);
      ctl_next.negate = point.first_value[DATA_WIDTH-1];
      y_next          = prod_b[GAIN_SHIFT +: WORK_WIDTH];
      z_next          = ctl_next.negate ? HALF_TURN : '0;
    end else begin
      ctl_next.origin = 1'b0;
      ctl_next.negate = fold;
      y_next          = '0;
      if (!fold) begin
        z_next = resid;
      end else if (resid > 0) begin
        z_next = resid - HALF_TURN;
      end else begin
        z_next = resid + HALF_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (point.ready) begin
      work_valid <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (point.ready && point.valid) begin
      work_ctl <= ctl_next;
      work_x   <= prod_a[GAIN_SHIFT +: WORK_WIDTH];
      work_y   <= y_next;
      work_z   <= z_next;
    end
  end

endmodule

>>> design/rpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter work queue
// Small first-in first-out buffer between the front end and the CORDIC.
// ----------------------------------------------------------------------------
module rpc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/rpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Converter CORDIC back end
// Pipelined CORDIC, one micro-rotation per stage, shared by vectoring and
// rotation, followed by rounding into the output register.
// ----------------------------------------------------------------------------
module rpc_back #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int WORK_WIDTH    = 34
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         work_valid,
  output logic                         work_ready,
  input  rpc_pkg::rpc_ctl_t            work_ctl,
  input  logic signed [WORK_WIDTH-1:0] work_x,
  input  logic signed [WORK_WIDTH-1:0] work_y,
  input  logic [rpc_pkg::PHASE_BITS:0] work_z,
  rpc_out_if.source                    result
);
  import rpc_pkg::*;

  localparam int ANG_SHIFT = PHASE_BITS - DATA_WIDTH;
  localparam logic [PHASE_BITS-1:0] ANG_RND =
      (ANG_SHIFT > 0) ? (PHASE_BITS'(1) << (ANG_SHIFT - 1)) : '0;
  localparam logic signed [WORK_WIDTH-1:0] COORD_RND = WORK_WIDTH'(1) << (GUARD_BITS - 1);

  logic                         vs [0:CORDIC_STAGES];
  rpc_ctl_t                     cs [0:CORDIC_STAGES];
  logic signed [WORK_WIDTH-1:0] xs [0:CORDIC_STAGES];
  logic signed [WORK_WIDTH-1:0] ys [0:CORDIC_STAGES];
  logic [PHASE_BITS:0]          zs [0:CORDIC_STAGES];

  logic                         advance;
  logic signed [WORK_WIDTH-1:0] x_rnd;
  logic signed [WORK_WIDTH-1:0] y_rnd;
  logic [PHASE_BITS-1:0]        phase_rnd;
  logic signed [DATA_WIDTH:0]   x_out;
  logic signed [DATA_WIDTH:0]   y_out;
  logic signed [DATA_WIDTH:0]   ang_out;
  logic signed [DATA_WIDTH:0]   first_next;
  logic signed [DATA_WIDTH:0]   second_next;

  // The whole pipeline moves together; it holds only when the output is full.
  assign advance    = !result.valid || result.ready;
  assign work_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (advance) begin
      vs[0] <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cs[0] <= work_ctl;
      xs[0] <= work_ctl.negate ? -work_x : work_x;
      ys[0] <= work_ctl.negate ? -work_y : work_y;
      zs[0] <= work_z;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [WORK_WIDTH-1:0] dx;
    logic signed [WORK_WIDTH-1:0] dy;
    logic [PHASE_BITS:0]          step;
    logic                         ccw;

    assign dx   = xs[i] >>> i;
    assign dy   = ys[i] >>> i;
    assign step = {1'b0, ATAN_TURN32[i]};
    // Vectoring drives y toward zero, rotation drives the residual angle toward zero.
    assign ccw  = (cs[i].mode == CMD_TO_RECT) ? !zs[i][PHASE_BITS] : ys[i][WORK_WIDTH-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (advance) begin
        vs[i+1] <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        cs[i+1] <= cs[i];
        if (ccw) begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - step;
        end else begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + step;
        end
      end
    end
  end

  assign x_rnd     = xs[CORDIC_STAGES] + COORD_RND;
  assign y_rnd     = ys[CORDIC_STAGES] + COORD_RND;
  assign phase_rnd = zs[CORDIC_STAGES][PHASE_BITS-1:0] + ANG_RND;
  assign x_out     = x_rnd[GUARD_BITS +: DATA_WIDTH + 1];
  assign y_out     = y_rnd[GUARD_BITS +: DATA_WIDTH + 1];
  assign ang_out   = {phase_rnd[PHASE_BITS-1], phase_rnd[PHASE_BITS-1:ANG_SHIFT]};

  always_comb begin
    if (cs[CORDIC_STAGES].mode == CMD_TO_RECT) begin
      first_next  = x_out;
      second_next = y_out;
    end else if (cs[CORDIC_STAGES].origin) begin
      first_next  = '0;
      second_next = '0;
    end else begin
      first_next  = x_out;
      second_next = ang_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= vs[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.first_result  <= first_next;
      result.second_result <= second_next;
    end
  end

endmodule

>>> design/rect_polar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangular/polar converter
// Gain-compensated CORDIC that converts points in either direction.
// ----------------------------------------------------------------------------
// Takes one point per clock while the work queue has room and returns one
// result per point, in order. A point is registered for the gain multiply and
// classification, held in the work queue, registered again to fold the start
// vector, then once per CORDIC stage and once for rounding. The
// sustained rate is one point per cycle, set by the fully unrolled CORDIC
// pipeline; a stalled result holds the pipeline while the front end keeps
// filling the queue. Coordinates are signed Q8.8; angles are binary units
// with 2^DATA_WIDTH per turn, and the origin converts to radius 0, angle 0.
module rect_polar_converter #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst,
  rpc_in_if.sink    point,
  rpc_out_if.source result
);
  import rpc_pkg::*;

  localparam int WORK_WIDTH = DATA_WIDTH + GUARD_BITS + 2;
  localparam int CTL_W      = $bits(rpc_ctl_t);
  localparam int ENTRY_W    = CTL_W + 2 * WORK_WIDTH + PHASE_BITS + 1;

  logic                         f_valid;
  logic                         f_ready;
  rpc_ctl_t                     f_ctl;
  logic signed [WORK_WIDTH-1:0] f_x;
  logic signed [WORK_WIDTH-1:0] f_y;
  logic [PHASE_BITS:0]          f_z;

  logic                         b_valid;
  logic                         b_ready;
  logic [ENTRY_W-1:0]           b_entry;
  rpc_ctl_t                     b_ctl;
  logic signed [WORK_WIDTH-1:0] b_x;
  logic signed [WORK_WIDTH-1:0] b_y;
  logic [PHASE_BITS:0]          b_z;

  rpc_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .WORK_WIDTH (WORK_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .point      (point),
    .work_valid (f_valid),
    .work_ready (f_ready),
    .work_ctl   (f_ctl),
    .work_x     (f_x),
    .work_y     (f_y),
    .work_z     (f_z)
  );

  rpc_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_ctl, f_x, f_y, f_z}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_entry)
  );

  assign b_z   = b_entry[PHASE_BITS:0];
  assign b_y   = b_entry[PHASE_BITS + 1 +: WORK_WIDTH];
  assign b_x   = b_entry[PHASE_BITS + 1 + WORK_WIDTH +: WORK_WIDTH];
  assign b_ctl = rpc_ctl_t'(b_entry[ENTRY_W-1 -: CTL_W]);

  rpc_back #(
    .DATA_WIDTH    (DATA_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES),
    .WORK_WIDTH    (WORK_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (b_valid),
    .work_ready (b_ready),
    .work_ctl   (b_ctl),
    .work_x     (b_x),
    .work_y     (b_y),
    .work_z     (b_z),
    .result     (result)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangular/polar converter testbench
// Sends points in both directions through the converter and compares every
// result with a bit-exact CORDIC model kept here, or with a fixed answer for
// the origin and zero-radius corner points. A short list of corner points
// comes first, then biased random points under three back-pressure profiles.
// ----------------------------------------------------------------------------
module testbench;
  import rpc_pkg::*;

  localparam int DW             = 16;
  localparam int NUM_STAGES     = 16;
  localparam int GUARD          = 16;
  localparam longint GAIN_Q30   = 652032875;
  localparam longint QUARTER    = 64'sd1 <<< 30;
  localparam longint HALF       = 64'sd1 <<< 31;
  localparam int LATENCY        = NUM_STAGES + 4;
  localparam int STALL_LIMIT    = 2000;
  localparam int ITEMS_PER_LOAD = 350;
  localparam int NUM_ROWS       = 22;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ARCTAN_STEP [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic signed [DW:0] first_result;
    logic signed [DW:0] second_result;
  } point_result_t;

  typedef struct {
    cmd_t               command;
    logic signed [DW-1:0] first_value;
    logic signed [DW-1:0] second_value;
    bit                 fixed_answer;
    logic signed [DW:0] first_result;
    logic signed [DW:0] second_result;
  } point_row_t;

  // Only the origin and a zero radius have answers that are obvious by eye.
  point_row_t corner_points [0:NUM_ROWS-1] = '{
    '{CMD_TO_POLAR,      0,      0, 1'b1, 0, 0},
    '{CMD_TO_POLAR,  32767,  32767, 1'b0, 0, 0},
    '{CMD_TO_POLAR, -32768, -32768, 1'b0, 0, 0},
    '{CMD_TO_POLAR, -32768,      0, 1'b0, 0, 0},
    '{CMD_TO_POLAR,   -256,      0, 1'b0, 0, 0},
    '{CMD_TO_POLAR,    256,      0, 1'b0, 0, 0},
    '{CMD_TO_POLAR,      0,    256, 1'b0, 0, 0},
    '{CMD_TO_POLAR,      0, -32768, 1'b0, 0, 0},
    '{CMD_TO_POLAR,  32767, -32768, 1'b0, 0, 0},
    '{CMD_TO_POLAR,     -1,      1, 1'b0, 0, 0},
    '{CMD_TO_POLAR,      1,     -1, 1'b0, 0, 0},
    '{CMD_TO_POLAR,   -300,     -1, 1'b0, 0, 0},
    '{CMD_TO_RECT,       0,  12345, 1'b1, 0, 0},
    '{CMD_TO_RECT,   32767,      0, 1'b0, 0, 0},
    '{CMD_TO_RECT,   32767,  16384, 1'b0, 0, 0},
    '{CMD_TO_RECT,   32767,  16385, 1'b0, 0, 0},
    '{CMD_TO_RECT,   32767, -16384, 1'b0, 0, 0},
    '{CMD_TO_RECT,   32767, -16385, 1'b0, 0, 0},
    '{CMD_TO_RECT,     256, -32768, 1'b0, 0, 0},
    '{CMD_TO_RECT,  -32768,   8192, 1'b0, 0, 0},
    '{CMD_TO_RECT,     256,  32767, 1'b0, 0, 0},
    '{CMD_TO_RECT,      -1,     -1, 1'b0, 0, 0}
  };

  logic clk;
  logic rst;

  rpc_in_if  #(.DATA_WIDTH(DW)) point_ch ();
  rpc_out_if #(.DATA_WIDTH(DW)) result_ch ();

  rect_polar_converter #(
    .DATA_WIDTH    (DW),
    .CORDIC_STAGES (NUM_STAGES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .point  (point_ch),
    .result (result_ch)
  );

  point_result_t pending_results [$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches = 0;
  int results_checked = 0;
  int polar_points;
  int rect_points;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  function automatic longint scale_by_gain(input longint v);
    return (v * GAIN_Q30) >>> (30 - GUARD);
  endfunction

  function automatic logic signed [DW:0] round_guard(input longint v);
    longint t;
    t = (v + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    return t[DW:0];
  endfunction

  function automatic point_result_t convert_point(input cmd_t cmd,
                                                  input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
    longint x, y, dx, dy, s, p;
    logic [31:0] phase;
    point_result_t r;
    r = '0;
    if (cmd == CMD_TO_POLAR) begin
      if (a == 0 && b == 0) return r;
      x = scale_by_gain(a);
      y = scale_by_gain(b);
      phase = 32'd0;
      // Points left of the y axis are turned by half a turn first.
      if (a < 0) begin
        x = -x;
        y = -y;
        phase = 32'h8000_0000;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y >= 0) begin
          x += dy;
          y -= dx;
          phase += ARCTAN_STEP[i];
        end else begin
          x -= dy;
          y += dx;
          phase -= ARCTAN_STEP[i];
        end
      end
      r.first_result = round_guard(x);
      p = (longint'(phase) + (64'sd1 <<< (31 - DW))) >>> (32 - DW);
      r.second_result = {p[DW-1], p[DW-1:0]};
    end else begin
      phase = 32'(unsigned'(b)) << (32 - DW);
      s = longint'(signed'(phase));
      x = scale_by_gain(a);
      y = 0;
      // Angles past a quarter turn start from the negated vector.
      if (s > QUARTER || s < -QUARTER) begin
        x = -x;
        s += (s > 0) ? -HALF : HALF;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (s >= 0) begin
          x -= dy;
          y += dx;
          s -= longint'(ARCTAN_STEP[i]);
        end else begin
          x += dy;
          y -= dx;
          s += longint'(ARCTAN_STEP[i]);
        end
      end
      r.first_result = round_guard(x);
      r.second_result = round_guard(y);
    end
    return r;
  endfunction

  // Biased value source: extremes, small magnitudes, angles near the
  // quarter-turn fold, or anything at all.
  function automatic logic signed [DW-1:0] draw_value(input bit near_fold);
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      1, 2: v = DW'($urandom_range(0, 2047) - 1024);
      3: begin
        if (near_fold) begin
          v = DW'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 4) - 2);
        end else begin
          v = DW'($urandom_range(0, 15) - 8);
        end
      end
      default: v = DW'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_point(input cmd_t cmd, input logic signed [DW-1:0] a,
                            input logic signed [DW-1:0] b, input bit fixed_answer,
                            input point_result_t answer);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(negedge clk);
    end
    point_ch.valid        <= 1'b1;
    point_ch.command      <= cmd;
    point_ch.first_value  <= a;
    point_ch.second_value <= b;
    do @(posedge clk); while (!point_ch.ready);
    pending_results.push_back(fixed_answer ? answer : convert_point(cmd, a, b));
    if (cmd == CMD_TO_POLAR) polar_points++;
    else rect_points++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    point_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Result channel back-pressure.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    point_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: first_result %0d second_result %0d",
               result_ch.first_result, result_ch.second_result);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result_ch.first_result !== want.first_result) begin
          $error("first_result: expected %0d, actual %0d",
                 want.first_result, result_ch.first_result);
          mismatches++;
        end
        if (result_ch.second_result !== want.second_result) begin
          $error("second_result: expected %0d, actual %0d",
                 want.second_result, result_ch.second_result);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    cmd_t cmd;
    clk = 1'b0;
    rst = 1'b1;
    point_ch.valid = 1'b0;
    point_ch.command = CMD_TO_POLAR;
    point_ch.first_value = '0;
    point_ch.second_value = '0;
    send_idle_pct = 17;
    recv_idle_pct = 62;
    polar_points = 0;
    rect_points = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (corner_points[i]) begin
      send_point(corner_points[i].command, corner_points[i].first_value,
                 corner_points[i].second_value, corner_points[i].fixed_answer,
                 '{corner_points[i].first_result, corner_points[i].second_result});
    end
    // Hold off the sender until every corner point has come back.
    drain_results();

    for (int load = 0; load < 3; load++) begin
      send_idle_pct = (load == 0) ? 17 : (load == 1) ? 62 : 0;
      recv_idle_pct = (load == 0) ? 62 : (load == 1) ? 17 : 0;
      for (int n = 0; n < ITEMS_PER_LOAD; n++) begin
        cmd = $urandom_range(0, 1) ? CMD_TO_RECT : CMD_TO_POLAR;
        if ($urandom_range(0, 29) == 0) begin
          a = 0;
          b = draw_value(cmd == CMD_TO_RECT);
          if (cmd == CMD_TO_POLAR) b = 0;
        end else if (cmd == CMD_TO_RECT) begin
          a = draw_value(1'b0);
          // Mostly non-negative radii; a negative one is legal and still converted.
          if ($urandom_range(0, 4) != 0 && a < 0) a = ~a;
          b = draw_value(1'b1);
        end else begin
          a = draw_value(1'b0);
          b = draw_value(1'b0);
        end
        send_point(cmd, a, b, 1'b0, '0);
      end
      drain_results();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("Converted %0d points to polar and %0d to rectangular form, %0d results checked,",
             polar_points, rect_points, results_checked);
    $display("covering corner points, the fold angles and three back-pressure profiles.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
design/rpc_pkg.sv
design/rpc_if.sv
design/rpc_front.sv
design/rpc_queue.sv
design/rpc_back.sv
design/rect_polar_converter.sv
tb/testbench.sv
